// ----- design/rrsi_pkg.sv -----
// shared constants and types for the rolling relative strength index block
`timescale 1ns / 1ps

package rrsi_pkg;

    localparam int PRICE_BITS  = 32;
    localparam int WINDOW_MAX  = 64;
    localparam int PTR_BITS    = 6;
    localparam int PERIOD_BITS = 7;
    localparam int SUM_BITS    = 38;
    localparam int RSI_BITS    = 14;
    localparam int QUOT_BITS   = 14;
    localparam int NUM_BITS    = 52;
    localparam int CNT_BITS    = 4;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 7'd14;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MIN   = 7'd1;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX   = 7'd64;

    localparam logic [RSI_BITS-1:0] RSI_NOT_READY = 14'd5000;
    localparam logic [RSI_BITS-1:0] RSI_FULL      = 14'd10000;
    localparam logic [RSI_BITS-1:0] RSI_SCALE     = 14'd10000;

    // how the back end has to finish a request
    localparam logic [1:0] KIND_NOT_READY = 2'd0;
    localparam logic [1:0] KIND_SATURATED = 2'd1;
    localparam logic [1:0] KIND_DIVIDE    = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SUM_BITS-1:0] gain;
        logic [SUM_BITS-1:0] loss;
    } qentry_t;

endpackage

// ----- design/rrsi_front.sv -----
// front end: price deltas, gain and loss rings, running window sums
`timescale 1ns / 1ps

module rrsi_front import rrsi_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [PERIOD_BITS-1:0] cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PRICE_BITS-1:0]  s_price,
    input  logic                   q_full,
    output logic                   q_push,
    output qentry_t                q_entry
);

    localparam logic F_IDLE   = 1'b0;
    localparam logic F_UPDATE = 1'b1;

    logic                    fstate_reg, fstate_next;
    logic [PERIOD_BITS-1:0]  period_reg, period_next;
    logic [PRICE_BITS-1:0]   last_price_reg, last_price_next;
    logic                    have_last_reg, have_last_next;
    logic [PRICE_BITS-1:0]   gain_reg, gain_next;
    logic [PRICE_BITS-1:0]   loss_reg, loss_next;
    logic [SUM_BITS-1:0]     gain_total_reg, gain_total_next;
    logic [SUM_BITS-1:0]     loss_total_reg, loss_total_next;
    logic [PERIOD_BITS-1:0]  fill_count_reg, fill_count_next;
    logic [PTR_BITS-1:0]     ring_pos_reg, ring_pos_next;

    logic [2*PRICE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [2*PRICE_BITS-1:0] ring_rd_reg;

    logic                    accept;
    logic                    evict;
    logic [SUM_BITS-1:0]     gain_upd, loss_upd;
    logic [PERIOD_BITS-1:0]  fill_upd;
    logic [PERIOD_BITS-1:0]  pos_inc;
    logic                    full;
    logic [PERIOD_BITS-1:0]  cfg_period;

    assign s_ready = (fstate_reg == F_IDLE) && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (cfg_data == '0) begin
            cfg_period = PERIOD_MIN;
        end else if (cfg_data > PERIOD_MAX) begin
            cfg_period = PERIOD_MAX;
        end else begin
            cfg_period = cfg_data;
        end
    end

    // window update from the slot about to be overwritten
    assign evict    = fill_count_reg >= period_reg;
    assign gain_upd = gain_total_reg
                      - (evict ? SUM_BITS'(ring_rd_reg[2*PRICE_BITS-1:PRICE_BITS]) : '0)
                      + SUM_BITS'(gain_reg);
    assign loss_upd = loss_total_reg
                      - (evict ? SUM_BITS'(ring_rd_reg[PRICE_BITS-1:0]) : '0)
                      + SUM_BITS'(loss_reg);
    assign fill_upd = evict ? fill_count_reg : fill_count_reg + 1'b1;
    assign full     = fill_upd >= period_reg;
    assign pos_inc  = PERIOD_BITS'(ring_pos_reg) + 1'b1;

    always_comb begin
        fstate_next     = fstate_reg;
        period_next     = period_reg;
        last_price_next = last_price_reg;
        have_last_next  = have_last_reg;
        gain_next       = gain_reg;
        loss_next       = loss_reg;
        gain_total_next = gain_total_reg;
        loss_total_next = loss_total_reg;
        fill_count_next = fill_count_reg;
        ring_pos_next   = ring_pos_reg;
        q_push          = 1'b0;
        q_entry.kind    = KIND_NOT_READY;
        q_entry.gain    = gain_upd;
        q_entry.loss    = loss_upd;

        if (cfg_valid) begin
            period_next     = cfg_period;
            last_price_next = '0;
            have_last_next  = 1'b0;
            gain_total_next = '0;
            loss_total_next = '0;
            fill_count_next = '0;
            ring_pos_next   = '0;
            fstate_next     = F_IDLE;
        end else begin
            case (fstate_reg)
                F_IDLE: begin
                    if (accept) begin
                        last_price_next = s_price;
                        if (!have_last_reg) begin
                            have_last_next = 1'b1;
                            q_push         = 1'b1;
                        end else begin
                            if (s_price > last_price_reg) begin
                                gain_next = s_price - last_price_reg;
                                loss_next = '0;
                            end else begin
                                gain_next = '0;
                                loss_next = last_price_reg - s_price;
                            end
                            fstate_next = F_UPDATE;
                        end
                    end
                end
                F_UPDATE: begin
                    gain_total_next = gain_upd;
                    loss_total_next = loss_upd;
                    fill_count_next = fill_upd;
                    ring_pos_next   = (pos_inc >= period_reg) ? '0 : pos_inc[PTR_BITS-1:0];
                    q_push          = 1'b1;
                    if (!full) begin
                        q_entry.kind = KIND_NOT_READY;
                    end else if (loss_upd == '0) begin
                        q_entry.kind = KIND_SATURATED;
                    end else begin
                        q_entry.kind = KIND_DIVIDE;
                    end
                    fstate_next = F_IDLE;
                end
                default: begin
                    fstate_next = F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg     <= F_IDLE;
            period_reg     <= PERIOD_RESET;
            last_price_reg <= '0;
            have_last_reg  <= 1'b0;
            gain_total_reg <= '0;
            loss_total_reg <= '0;
            fill_count_reg <= '0;
            ring_pos_reg   <= '0;
        end else begin
            fstate_reg     <= fstate_next;
            period_reg     <= period_next;
            last_price_reg <= last_price_next;
            have_last_reg  <= have_last_next;
            gain_total_reg <= gain_total_next;
            loss_total_reg <= loss_total_next;
            fill_count_reg <= fill_count_next;
            ring_pos_reg   <= ring_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg <= gain_next;
        loss_reg <= loss_next;
    end

    // ring read during accept, write back in the update cycle
    always_ff @(posedge aclk) begin
        ring_rd_reg <= ring_mem[ring_pos_reg];
        if (fstate_reg == F_UPDATE && !cfg_valid) begin
            ring_mem[ring_pos_reg] <= {gain_reg, loss_reg};
        end
    end

endmodule

// ----- design/rrsi_queue.sv -----
// two-entry request queue between front and back end
`timescale 1ns / 1ps

module rrsi_queue import rrsi_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  qentry_t push_entry,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output qentry_t head_entry
);

    qentry_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- design/rrsi_back.sv -----
// back end: bit-serial ratio divider and output register
`timescale 1ns / 1ps

module rrsi_back import rrsi_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  qentry_t             head_entry,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RSI_BITS-1:0] m_rsi_centi,
    output logic                m_ready_res
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]           bstate_reg, bstate_next;
    logic [NUM_BITS-1:0]  rem_reg, rem_next;
    logic [NUM_BITS-1:0]  div_reg, div_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [RSI_BITS-1:0]  rsi_reg, rsi_next;
    logic                 res_reg, res_next;

    logic                 out_free;
    logic                 ge;
    logic [SUM_BITS:0]    denom;

    assign out_free    = !m_valid_reg || m_ready;
    assign ge          = rem_reg >= div_reg;
    assign denom       = {1'b0, head_entry.gain} + {1'b0, head_entry.loss};
    assign m_valid     = m_valid_reg;
    assign m_rsi_centi = rsi_reg;
    assign m_ready_res = res_reg;

    always_comb begin
        bstate_next  = bstate_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        rsi_next     = rsi_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pop          = 1'b0;

        case (bstate_reg)
            B_IDLE: begin
                if (head_valid) begin
                    case (head_entry.kind)
                        KIND_DIVIDE: begin
                            pop         = 1'b1;
                            rem_next    = NUM_BITS'(head_entry.gain) * NUM_BITS'(RSI_SCALE);
                            div_next    = NUM_BITS'(denom) << (QUOT_BITS - 1);
                            cnt_next    = CNT_BITS'(QUOT_BITS - 1);
                            bstate_next = B_DIV;
                        end
                        KIND_SATURATED: begin
                            if (out_free) begin
                                pop          = 1'b1;
                                rsi_next     = RSI_FULL;
                                res_next     = 1'b1;
                                m_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                pop          = 1'b1;
                                rsi_next     = RSI_NOT_READY;
                                res_next     = 1'b0;
                                m_valid_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            B_DIV: begin
                // restoring step, one quotient bit per cycle
                if (ge) begin
                    rem_next = rem_reg - div_reg;
                end
                quot_next = {quot_reg[QUOT_BITS-2:0], ge};
                div_next  = div_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    bstate_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    rsi_next     = quot_reg;
                    res_next     = 1'b1;
                    m_valid_next = 1'b1;
                    bstate_next  = B_IDLE;
                end
            end
            default: begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bstate_reg  <= B_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            bstate_reg  <= bstate_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        rsi_reg  <= rsi_next;
        res_reg  <= res_next;
    end

endmodule

// ----- design/rolling_relative_strength_index.sv -----
// not-ready and saturated results go straight to the output register, divided ones
// through the divider; the front end takes no price in its update state, and a divided
// result holds the back end (14-bit restoring divider, one quotient bit per cycle)
// a two-entry queue lets the front end run ahead of the divider
// reset: synchronous active-low aresetn clears history, queue and output; period goes to 14
`timescale 1ns / 1ps

module rolling_relative_strength_index import rrsi_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [PERIOD_BITS-1:0] cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PRICE_BITS-1:0]  s_price,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [RSI_BITS-1:0]    m_rsi_centi,
    output logic                   m_ready_res
);

    logic    q_full;
    logic    q_push;
    qentry_t q_entry;
    logic    q_pop;
    logic    q_head_valid;
    qentry_t q_head;

    assign cfg_ready = 1'b1;

    rrsi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_price   (s_price),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    rrsi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    rrsi_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_head_valid),
        .head_entry  (q_head),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsi_centi (m_rsi_centi),
        .m_ready_res (m_ready_res)
    );

endmodule

// ----- sim/rolling_relative_strength_index_test.sv -----
// testbench for the rolling relative strength index block with an rsi predictor and scoreboard
`timescale 1ns / 1ps

module rolling_relative_strength_index_test;
    import rrsi_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi_centi;
        logic                ready_res;
    } rsi_result_t;

    class rsi_tracker;
        logic [PERIOD_BITS-1:0] period_reg;
        logic [PRICE_BITS-1:0]  last_price;
        bit                     have_last;
        logic [PRICE_BITS-1:0]  gain_ring [WINDOW_MAX];
        logic [PRICE_BITS-1:0]  loss_ring [WINDOW_MAX];
        logic [SUM_BITS-1:0]    gain_sum;
        logic [SUM_BITS-1:0]    loss_sum;
        logic [PERIOD_BITS-1:0] fill;
        logic [PTR_BITS-1:0]    slot;
        rsi_result_t            expected_rsi [$];
        int mismatches;
        int prices_seen;
        int results_seen;
        int full_windows;
        int period_writes;

        function new();
            period_reg    = PERIOD_RESET;
            mismatches    = 0;
            prices_seen   = 0;
            results_seen  = 0;
            full_windows  = 0;
            period_writes = 0;
            clear_history();
        endfunction

        function void clear_history();
            last_price = '0;
            have_last  = 1'b0;
            gain_sum   = '0;
            loss_sum   = '0;
            fill       = '0;
            slot       = '0;
        endfunction

        function void set_period(logic [PERIOD_BITS-1:0] value);
            period_reg = value;
            period_writes++;
            clear_history();
        endfunction

        function int window_len();
            if (period_reg == 0)
                return 1;
            if (period_reg > WINDOW_MAX)
                return WINDOW_MAX;
            return int'(period_reg);
        endfunction

        function int pending();
            return expected_rsi.size();
        endfunction

        function void note_price(logic [PRICE_BITS-1:0] price);
            logic [PRICE_BITS-1:0] up;
            logic [PRICE_BITS-1:0] down;
            rsi_result_t           res;
            longint unsigned       g;
            longint unsigned       s;
            int                    len;
            len = window_len();
            prices_seen++;
            res.rsi_centi = RSI_NOT_READY;
            res.ready_res = 1'b0;
            if (!have_last) begin
                last_price = price;
                have_last  = 1'b1;
                expected_rsi = {expected_rsi, res};
                return;
            end
            up   = '0;
            down = '0;
            if (price > last_price)
                up = price - last_price;
            else
                down = last_price - price;
            last_price = price;
            // oldest change drops out once the window is full
            if (int'(fill) >= len) begin
                gain_sum = gain_sum - gain_ring[slot];
                loss_sum = loss_sum - loss_ring[slot];
            end else begin
                fill = fill + 1'b1;
            end
            gain_ring[slot] = up;
            loss_ring[slot] = down;
            gain_sum = gain_sum + up;
            loss_sum = loss_sum + down;
            if (int'(slot) + 1 >= len)
                slot = '0;
            else
                slot = slot + 1'b1;
            if (int'(fill) >= len) begin
                res.ready_res = 1'b1;
                if (loss_sum == 0) begin
                    res.rsi_centi = RSI_FULL;
                end else begin
                    g = gain_sum;
                    s = g + loss_sum;
                    res.rsi_centi = RSI_BITS'((g * longint'(RSI_SCALE)) / s);
                end
            end
            expected_rsi = {expected_rsi, res};
        endfunction

        function void check_result(logic [RSI_BITS-1:0] rsi, logic rdy);
            rsi_result_t want;
            results_seen++;
            if (rdy)
                full_windows++;
            if (expected_rsi.size() == 0) begin
                $display("%0t: result with nothing expected, rsi_centi %0d ready_res %0d",
                         $time, rsi, rdy);
                mismatches++;
                return;
            end
            want = expected_rsi.pop_front();
            if (rsi !== want.rsi_centi) begin
                $display("%0t: rsi_centi mismatch, expected %0d got %0d",
                         $time, want.rsi_centi, rsi);
                mismatches++;
            end
            if (rdy !== want.ready_res) begin
                $display("%0t: ready_res mismatch, expected %0d got %0d",
                         $time, want.ready_res, rdy);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [PERIOD_BITS-1:0] cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [PRICE_BITS-1:0]  s_price;
    logic                   m_valid;
    logic                   m_ready;
    logic [RSI_BITS-1:0]    m_rsi_centi;
    logic                   m_ready_res;

    rsi_tracker tracker = new();

    logic [PRICE_BITS-1:0] price_trail = '0;
    bit receiver_hold = 1'b0;
    bit no_idle = 1'b0;
    int held_cycles = 0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    rolling_relative_strength_index u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_price     (s_price),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsi_centi (m_rsi_centi),
        .m_ready_res (m_ready_res)
    );

    function automatic int pick_gap();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly a random walk so the index moves around, with jumps, flats and rails
    function automatic logic [PRICE_BITS-1:0] next_price();
        int unsigned           roll;
        logic [PRICE_BITS-1:0] value;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            value = price_trail + $urandom_range(0, 2000) - 32'd1000;
        else if (roll < 85)
            value = $urandom;
        else if (roll < 95)
            value = price_trail;
        else
            value = ($urandom_range(0, 1) != 0) ? '1 : '0;
        price_trail = value;
        return value;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_period(cfg_data);
            if (s_valid && s_ready)
                tracker.note_price(s_price);
            if (m_valid && m_ready)
                tracker.check_result(m_rsi_centi, m_ready_res);
        end
    end

    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("rolling_relative_strength_index_test: errors");
                $finish;
            end
        end
    end

    // result side
    initial begin
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (receiver_hold) begin
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge aclk);
                    held_cycles++;
                end
                receiver_hold = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    task automatic send_price(input logic [PRICE_BITS-1:0] price, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_price <= price;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_walk(input int count, input bit eager);
        int k;
        for (k = 0; k < count; k++)
            send_price(next_price(), eager ? 0 : pick_gap());
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_period(input logic [PERIOD_BITS-1:0] value);
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_list(input logic [PRICE_BITS-1:0] prices [$]);
        int k;
        for (k = 0; k < prices.size(); k++)
            send_price(prices[k], pick_gap());
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [PERIOD_BITS-1:0] period_pick;
        int                     k;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_price   = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset period, first sample then a fill up to a full window
        send_walk(30, 1'b0);

        // rails, no-change steps and full-scale moves on a short window
        write_period(7'd2);
        send_list('{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
                    32'h1, 32'h8000_0000, 32'h7FFF_FFFF});
        write_period(7'd1);
        send_list('{32'd5, 32'd5, 32'd3, 32'd9, 32'd8});
        // same value again still restarts the history
        write_period(7'd1);
        send_list('{32'd8, 32'd8, 32'd7, 32'hFFFF_FFFF});

        for (k = 0; k < 12; k++) begin
            case (k)
                0: period_pick = PERIOD_MAX;
                1: period_pick = 7'd0;
                2: period_pick = 7'd127;
                3: period_pick = PERIOD_MAX + 7'd1;
                4: period_pick = 7'd3;
                5: period_pick = PERIOD_MIN;
                6: period_pick = PERIOD_RESET;
                11: period_pick = 7'($urandom_range(0, 127));
                default: period_pick = 7'($urandom_range(1, 64));
            endcase
            write_period(period_pick);
            no_idle = ($urandom_range(0, 3) == 0);
            if (k == 4) begin
                // receiver stalls long while prices keep coming
                receiver_hold = 1'b1;
                send_walk(45, 1'b1);
            end else begin
                send_walk((k == 0 || k == 2) ? 90 : 45, 1'b0);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d prices and %0d results (%0d with a full window)",
                 tracker.prices_seen, tracker.results_seen, tracker.full_windows);
        $display("over %0d period writes; receiver held off for %0d cycles while prices kept coming",
                 tracker.period_writes, held_cycles);
        if (tracker.mismatches == 0)
            $display("rolling_relative_strength_index_test: clean");
        else
            $display("rolling_relative_strength_index_test: errors");
        $finish;
    end

endmodule
